// ----- hdl/xvts_pkg.sv -----
// shared types, codes and constants for the vbr header parser and toc seek
// no dependencies; every module of the block imports it

package xvts_pkg;

    localparam int TOC_LEN   = 100;
    localparam int TOC_AW    = 7;
    localparam int POS_W     = 7;
    localparam int MUL_AW    = 17;
    localparam int MUL_BW    = 32;
    localparam int MUL_PW    = MUL_AW + MUL_BW;

    localparam logic [TOC_AW-1:0] TOC_LAST  = 7'd99;
    localparam logic [TOC_AW-1:0] TOC_SIZE  = 7'd100;
    localparam logic [15:0]       PCT_MAX   = 16'd25600;
    localparam logic [8:0]        FRAC_ONE  = 9'd256;

    localparam logic [1:0] ACT_START = 2'd0;
    localparam logic [1:0] ACT_NEXT  = 2'd1;
    localparam logic [1:0] ACT_SEEK  = 2'd2;

    localparam logic [2:0] ST_CONSUMED   = 3'd0;
    localparam logic [2:0] ST_HDR_OK     = 3'd1;
    localparam logic [2:0] ST_BAD_ID     = 3'd2;
    localparam logic [2:0] ST_INCOMPLETE = 3'd3;
    localparam logic [2:0] ST_IGNORED    = 3'd4;
    localparam logic [2:0] ST_SEEK_OK    = 3'd5;
    localparam logic [2:0] ST_SEEK_REF   = 3'd6;

    localparam int FLG_FRAMES = 0;
    localparam int FLG_BYTES  = 1;
    localparam int FLG_TOC    = 2;
    localparam int FLG_QUAL   = 3;

    localparam logic [7:0] ID_XING [4] = '{8'h58, 8'h69, 8'h6E, 8'h67};
    localparam logic [7:0] ID_INFO [4] = '{8'h49, 8'h6E, 8'h66, 8'h6F};

    typedef struct packed {
        logic              en;
        logic              clr;
        logic [MUL_AW-1:0] a;
        logic [MUL_BW-1:0] b;
    } t_mac_op;

    typedef struct packed {
        logic              en;
        logic [TOC_AW-1:0] addr;
        logic [7:0]        data;
    } t_toc_wr;

    typedef struct packed {
        logic [31:0] frames;
        logic [31:0] bytes;
        logic [31:0] qual;
        logic        table_present;
        logic        seek_ok;
    } t_hdr_view;

endpackage

// ----- hdl/xing_vbr_header_toc_seek_core.sv -----
// top level of the vbr header parser with toc seek: handshakes and item control
// depends on xvts_pkg, xvts_hdr and xvts_seek
//
//  channel  | direction | handshake         | payload
//  ---------+-----------+-------------------+----------------------------------------------
//  input    | in        | i_valid / o_stall | i_action, i_header_byte, i_seek_percent
//  result   | out       | o_valid / i_stall | o_status, o_seek_point, o_frame_total,
//           |           |                   | o_byte_total, o_quality_word, o_table_present
//
// a header byte or ignored item passes through the byte and emit states, a refused seek only emit
// an accepted seek query makes two toc memory reads and three passes through
// the shared 17 x 32 multiply-accumulate unit
// o_stall is high from accept until the result beat is loaded into the output register
// a stalled result beat holds; the next item is taken while it waits
// reset is synchronous and active low; toc contents are not reset

module xing_vbr_header_toc_seek_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_action,
    input  logic [7:0]  i_header_byte,
    input  logic [15:0] i_seek_percent,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_status,
    output logic [31:0] o_seek_point,
    output logic [31:0] o_frame_total,
    output logic [31:0] o_byte_total,
    output logic [31:0] o_quality_word,
    output logic        o_table_present
);
    import xvts_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_BYTE = 2'd1;
    localparam logic [1:0] S_SEEK = 2'd2;
    localparam logic [1:0] S_EMIT = 2'd3;

    logic [1:0]  r_state, n_state;
    logic        r_out_valid, n_out_valid;
    logic [1:0]  r_action;
    logic [7:0]  r_byte;
    logic [2:0]  r_status;
    logic [31:0] r_point;

    logic        w_accept;
    logic        w_out_free;
    logic        w_emit;
    logic        w_seek_start;
    logic        w_seek_done;
    logic [31:0] w_seek_point;
    logic [2:0]  w_hdr_status;
    t_toc_wr     w_toc_wr;
    t_hdr_view   w_view;

    assign w_accept     = i_valid && !o_stall;
    assign w_out_free   = !r_out_valid || !i_stall;
    assign w_emit       = (r_state == S_EMIT) && w_out_free;
    assign w_seek_start = w_accept && (i_action == ACT_SEEK) && w_view.seek_ok;

    xvts_hdr u_hdr (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (r_state == S_BYTE),
        .i_action (r_action),
        .i_byte   (r_byte),
        .o_status (w_hdr_status),
        .o_toc_wr (w_toc_wr),
        .o_view   (w_view)
    );

    xvts_seek u_seek (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_toc_wr (w_toc_wr),
        .i_start  (w_seek_start),
        .i_pct    (i_seek_percent),
        .i_bytes  (w_view.bytes),
        .o_done   (w_seek_done),
        .o_point  (w_seek_point)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_action == ACT_SEEK) begin
                        n_state = w_view.seek_ok ? S_SEEK : S_EMIT;
                    end else begin
                        n_state = S_BYTE;
                    end
                end
            end
            S_BYTE: begin
                n_state = S_EMIT;
            end
            S_SEEK: begin
                if (w_seek_done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign n_out_valid = w_emit || (r_out_valid && i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_action <= i_action;
            r_byte   <= i_header_byte;
            r_status <= ST_SEEK_REF;
            r_point  <= '0;
        end
        if (r_state == S_BYTE) begin
            r_status <= w_hdr_status;
        end
        if ((r_state == S_SEEK) && w_seek_done) begin
            r_status <= ST_SEEK_OK;
            r_point  <= w_seek_point;
        end
        if (w_emit) begin
            o_status        <= r_status;
            o_seek_point    <= r_point;
            o_frame_total   <= w_view.frames;
            o_byte_total    <= w_view.bytes;
            o_quality_word  <= w_view.qual;
            o_table_present <= w_view.table_present;
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;

`ifndef ASSERT_OFF
    a_done_in_seek: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_seek_done |-> (r_state == S_SEEK))
        else $error("seek unit finished outside a seek item");

    a_point_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_seek_done |-> (w_seek_point <= w_view.bytes))
        else $error("seek point beyond byte total");

    a_emit_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |=> (o_valid && (r_state == S_IDLE)))
        else $error("result beat not presented after emit");

    a_seek_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_seek_start |=> (r_state == S_SEEK))
        else $error("seek started without entering seek state");
`endif

endmodule

// ----- hdl/xvts_mac.sv -----
// shared multiply-accumulate unit, 17 x 32 bits, result registered
// depends on xvts_pkg

module xvts_mac (
    input  logic                         i_clk,
    input  xvts_pkg::t_mac_op            i_op,
    output logic [xvts_pkg::MUL_PW-1:0]  o_acc
);
    import xvts_pkg::*;

    logic [MUL_PW-1:0] w_prod;
    logic [MUL_PW-1:0] r_acc;
    logic [MUL_PW-1:0] n_acc;

    assign w_prod = MUL_PW'(i_op.a) * MUL_PW'(i_op.b);

    always_comb begin
        n_acc = r_acc;
        if (i_op.en) begin
            n_acc = (i_op.clr ? '0 : r_acc) + w_prod;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
    end

    assign o_acc = r_acc;

endmodule

// ----- hdl/xvts_hdr.sv -----
// header byte parser: id check, flags, counts, quality word and toc writes
// depends on xvts_pkg

module xvts_hdr (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic [1:0]           i_action,
    input  logic [7:0]           i_byte,
    output logic [2:0]           o_status,
    output xvts_pkg::t_toc_wr    o_toc_wr,
    output xvts_pkg::t_hdr_view  o_view
);
    import xvts_pkg::*;

    logic [POS_W-1:0] r_pos, n_pos;
    logic             r_mx, n_mx;
    logic             r_mi, n_mi;
    logic [3:0]       r_flags, n_flags;
    logic [31:0]      r_shift, n_shift;
    logic [31:0]      r_frames, n_frames;
    logic [31:0]      r_bytes, n_bytes;
    logic [31:0]      r_qual, n_qual;
    logic             r_hvalid, n_hvalid;

    logic             w_start;
    logic             w_feed;
    logic [POS_W-1:0] w_pos;
    logic [3:0]       w_flags;
    logic [POS_W-1:0] w_s_bytes, w_s_toc, w_s_qual, w_len;
    logic [POS_W-1:0] w_pos_inc;

    assign w_start   = (i_action == ACT_START);
    assign w_feed    = w_start || ((i_action == ACT_NEXT) && (r_pos != '0));
    assign w_pos     = w_start ? '0 : r_pos;
    assign w_pos_inc = w_pos + 7'd1;

    // field boundaries follow the flags in force after this byte
    assign w_flags   = (w_feed && (w_pos == 7'd7)) ? i_byte[3:0] : r_flags;
    assign w_s_bytes = 7'd8 + (w_flags[FLG_FRAMES] ? 7'd4 : 7'd0);
    assign w_s_toc   = w_s_bytes + (w_flags[FLG_BYTES] ? 7'd4 : 7'd0);
    assign w_s_qual  = w_s_toc + (w_flags[FLG_TOC] ? TOC_SIZE : 7'd0);
    assign w_len     = w_s_qual + (w_flags[FLG_QUAL] ? 7'd4 : 7'd0);

    always_comb begin
        n_pos    = r_pos;
        n_mx     = r_mx;
        n_mi     = r_mi;
        n_flags  = r_flags;
        n_shift  = r_shift;
        n_frames = r_frames;
        n_bytes  = r_bytes;
        n_qual   = r_qual;
        n_hvalid = r_hvalid;
        o_status = ST_IGNORED;
        o_toc_wr = '0;
        if (w_start) begin
            n_mx     = 1'b1;
            n_mi     = 1'b1;
            n_flags  = '0;
            n_shift  = '0;
            n_frames = '0;
            n_bytes  = '0;
            n_qual   = '1;
            n_hvalid = 1'b0;
        end
        if (w_feed) begin
            n_shift  = {n_shift[23:0], i_byte};
            o_status = ST_CONSUMED;
            if (w_pos < 7'd4) begin
                n_mx  = n_mx && (i_byte == ID_XING[w_pos[1:0]]);
                n_mi  = n_mi && (i_byte == ID_INFO[w_pos[1:0]]);
                n_pos = w_pos_inc;
                if ((w_pos == 7'd3) && !n_mx && !n_mi) begin
                    n_pos    = '0;
                    o_status = ST_BAD_ID;
                end
            end else begin
                if (w_pos == 7'd7) begin
                    n_flags = n_shift[3:0];
                end else if (w_pos > 7'd7) begin
                    if (n_flags[FLG_FRAMES] && (w_pos == w_s_bytes - 7'd1)) begin
                        n_frames = n_shift;
                    end
                    if (n_flags[FLG_BYTES] && (w_pos == w_s_toc - 7'd1)) begin
                        n_bytes = n_shift;
                    end
                    if ((w_pos >= w_s_toc) && (w_pos < w_s_qual)) begin
                        o_toc_wr.en   = i_en;
                        o_toc_wr.addr = w_pos - w_s_toc;
                        o_toc_wr.data = i_byte;
                    end
                    if (n_flags[FLG_QUAL] && (w_pos == w_len - 7'd1)) begin
                        n_qual = n_shift;
                    end
                end
                n_pos = w_pos_inc;
                if ((w_pos >= 7'd7) && (w_pos_inc >= w_len)) begin
                    n_pos    = '0;
                    n_hvalid = (n_frames != '0) && (n_bytes != '0);
                    o_status = n_hvalid ? ST_HDR_OK : ST_INCOMPLETE;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_mx     <= 1'b0;
            r_mi     <= 1'b0;
            r_flags  <= '0;
            r_shift  <= '0;
            r_frames <= '0;
            r_bytes  <= '0;
            r_qual   <= '1;
            r_hvalid <= 1'b0;
        end else if (i_en) begin
            r_pos    <= n_pos;
            r_mx     <= n_mx;
            r_mi     <= n_mi;
            r_flags  <= n_flags;
            r_shift  <= n_shift;
            r_frames <= n_frames;
            r_bytes  <= n_bytes;
            r_qual   <= n_qual;
            r_hvalid <= n_hvalid;
        end
    end

    assign o_view.frames        = r_frames;
    assign o_view.bytes         = r_bytes;
    assign o_view.qual          = r_qual;
    assign o_view.table_present = (r_pos == '0) && r_flags[FLG_TOC];
    assign o_view.seek_ok       = r_hvalid && r_flags[FLG_TOC] && (r_bytes != '0);

endmodule

// ----- hdl/xvts_seek.sv -----
// toc memory and seek sequencer: interpolation and byte scaling on the shared mac
// depends on xvts_pkg and xvts_mac

module xvts_seek (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  xvts_pkg::t_toc_wr    i_toc_wr,
    input  logic                 i_start,
    input  logic [15:0]          i_pct,
    input  logic [31:0]          i_bytes,
    output logic                 o_done,
    output logic [31:0]          o_point
);
    import xvts_pkg::*;

    localparam logic [2:0] K_IDLE = 3'd0;
    localparam logic [2:0] K_RD0  = 3'd1;
    localparam logic [2:0] K_M0   = 3'd2;
    localparam logic [2:0] K_M1   = 3'd3;
    localparam logic [2:0] K_M2   = 3'd4;
    localparam logic [2:0] K_FIN  = 3'd5;

    logic [7:0]        r_mem [TOC_LEN];
    logic [7:0]        r_rd;
    logic [TOC_AW-1:0] w_rd_addr;

    logic [2:0]        r_state, n_state;
    logic [TOC_AW-1:0] r_a;
    logic [8:0]        r_f;
    logic              r_last;

    logic [15:0]       w_p;
    logic [TOC_AW-1:0] w_a;
    logic [8:0]        w_fb;
    t_mac_op           w_op;
    logic [MUL_PW-1:0] w_acc;

    assign w_p = (i_pct > PCT_MAX) ? PCT_MAX : i_pct;
    assign w_a = (w_p[15:8] > 8'(TOC_LAST)) ? TOC_LAST : w_p[14:8];

    always_ff @(posedge i_clk) begin
        if (i_toc_wr.en) begin
            r_mem[i_toc_wr.addr] <= i_toc_wr.data;
        end
        r_rd <= r_mem[w_rd_addr];
    end

    assign w_rd_addr = ((r_state == K_RD0) || r_last) ? r_a : r_a + 7'd1;
    assign w_fb      = r_last ? FRAC_ONE : {1'b0, r_rd};

    always_comb begin
        n_state = r_state;
        w_op    = '0;
        case (r_state)
            K_IDLE: begin
                if (i_start) begin
                    n_state = K_RD0;
                end
            end
            K_RD0: begin
                n_state = K_M0;
            end
            K_M0: begin
                w_op.en  = 1'b1;
                w_op.clr = 1'b1;
                w_op.a   = MUL_AW'(FRAC_ONE - r_f);
                w_op.b   = MUL_BW'(r_rd);
                n_state  = K_M1;
            end
            K_M1: begin
                w_op.en = 1'b1;
                w_op.a  = MUL_AW'(r_f);
                w_op.b  = MUL_BW'(w_fb);
                n_state = K_M2;
            end
            K_M2: begin
                w_op.en  = 1'b1;
                w_op.clr = 1'b1;
                w_op.a   = w_acc[MUL_AW-1:0];
                w_op.b   = i_bytes;
                n_state  = K_FIN;
            end
            K_FIN: begin
                n_state = K_IDLE;
            end
            default: begin
                n_state = K_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= K_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == K_IDLE) && i_start) begin
            r_a    <= w_a;
            r_f    <= 9'(w_p - {1'b0, w_a, 8'b0});
            r_last <= (w_a == TOC_LAST);
        end
    end

    xvts_mac u_mac (
        .i_clk (i_clk),
        .i_op  (w_op),
        .o_acc (w_acc)
    );

    assign o_done  = (r_state == K_FIN);
    assign o_point = w_acc[47:16];

endmodule

// ----- tb/xvts_result_checker.sv -----
// result checker for the vbr header parser: watches both channels, predicts each beat
// depends on xvts_pkg; instantiated beside the block by the testbench top

module xvts_result_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [1:0]  i_action,
    input  logic [7:0]  i_header_byte,
    input  logic [15:0] i_seek_percent,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [2:0]  i_status,
    input  logic [31:0] i_seek_point,
    input  logic [31:0] i_frame_total,
    input  logic [31:0] i_byte_total,
    input  logic [31:0] i_quality_word,
    input  logic        i_table_present,
    output int          o_pending,
    output int          o_fail_count
);
    import xvts_pkg::*;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] seek_point;
        logic [31:0] frames;
        logic [31:0] bytes;
        logic [31:0] quality;
        logic        table_present;
    } t_hdr_beat;

    typedef enum {SEC_NONE, SEC_FRAMES, SEC_BYTES, SEC_TOC, SEC_QUAL} t_hdr_section;

    logic [6:0]  parse_pos;
    logic        xing_ok;
    logic        info_ok;
    logic [3:0]  flags;
    logic [31:0] shift_word;
    logic [31:0] frames_cnt;
    logic [31:0] bytes_cnt;
    logic [31:0] quality_cnt;
    logic [7:0]  toc [TOC_LEN];
    logic        hdr_ok;

    t_hdr_beat   expected_beats [$];
    t_hdr_beat   got_beat;
    t_hdr_beat   want_beat;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch on %s: got %0h, expected %0h (t=%0t)", what, got, want, $time);
        o_fail_count++;
    endtask

    function automatic void clear_parser();
        parse_pos   = '0;
        xing_ok     = 1'b0;
        info_ok     = 1'b0;
        flags       = '0;
        shift_word  = '0;
        frames_cnt  = '0;
        bytes_cnt   = '0;
        quality_cnt = '1;
        hdr_ok      = 1'b0;
    endfunction

    function automatic int header_bytes();
        int n;
        n = 8;
        if (flags[FLG_FRAMES]) n += 4;
        if (flags[FLG_BYTES]) n += 4;
        if (flags[FLG_TOC]) n += TOC_LEN;
        if (flags[FLG_QUAL]) n += 4;
        return n;
    endfunction

    function automatic t_hdr_section field_of(input int pos, output int off);
        int o;
        o = pos - 8;
        off = 0;
        if (flags[FLG_FRAMES]) begin
            if (o < 4) begin
                off = o;
                return SEC_FRAMES;
            end
            o -= 4;
        end
        if (flags[FLG_BYTES]) begin
            if (o < 4) begin
                off = o;
                return SEC_BYTES;
            end
            o -= 4;
        end
        if (flags[FLG_TOC]) begin
            if (o < TOC_LEN) begin
                off = o;
                return SEC_TOC;
            end
            o -= TOC_LEN;
        end
        if (flags[FLG_QUAL] && o < 4) begin
            off = o;
            return SEC_QUAL;
        end
        return SEC_NONE;
    endfunction

    function automatic logic [2:0] take_byte(input logic [7:0] b);
        int pos;
        int off;
        t_hdr_section sec;
        pos = parse_pos;
        shift_word = {shift_word[23:0], b};
        if (pos < 4) begin
            if (b != ID_XING[pos]) xing_ok = 1'b0;
            if (b != ID_INFO[pos]) info_ok = 1'b0;
            if (pos == 3 && !xing_ok && !info_ok) begin
                parse_pos = '0;
                return ST_BAD_ID;
            end
            parse_pos = 7'(pos + 1);
            return ST_CONSUMED;
        end
        if (pos == 7) begin
            flags = shift_word[3:0];
        end else if (pos > 7) begin
            sec = field_of(pos, off);
            case (sec)
                SEC_FRAMES: if (off == 3) frames_cnt = shift_word;
                SEC_BYTES:  if (off == 3) bytes_cnt = shift_word;
                SEC_TOC:    toc[off] = b;
                SEC_QUAL:   if (off == 3) quality_cnt = shift_word;
                default: ;
            endcase
        end
        if (pos >= 7 && pos + 1 >= header_bytes()) begin
            parse_pos = '0;
            hdr_ok = (frames_cnt != 0) && (bytes_cnt != 0);
            return hdr_ok ? ST_HDR_OK : ST_INCOMPLETE;
        end
        parse_pos = 7'(pos + 1);
        return ST_CONSUMED;
    endfunction

    // table value in 8.8, scaled by the byte count and truncated
    function automatic logic [31:0] seek_target(input logic [15:0] pct);
        logic [15:0] p;
        int          a;
        logic [63:0] f;
        logic [63:0] fa;
        logic [63:0] fb;
        logic [63:0] x;
        logic [63:0] prod;
        p = (pct > PCT_MAX) ? PCT_MAX : pct;
        a = int'(p) >> 8;
        if (a > TOC_LAST) a = int'(TOC_LAST);
        f = 64'(int'(p) - a * 256);
        fa = 64'(toc[a]);
        fb = (a < TOC_LAST) ? 64'(toc[a + 1]) : 64'(FRAC_ONE);
        x = fa * (64'd256 - f) + fb * f;
        prod = x * 64'(bytes_cnt);
        return prod[47:16];
    endfunction

    function automatic t_hdr_beat predict_beat(input logic [1:0] act, input logic [7:0] b,
                                               input logic [15:0] pct);
        t_hdr_beat r;
        r.status = ST_IGNORED;
        r.seek_point = '0;
        case (act)
            ACT_START: begin
                clear_parser();
                xing_ok = 1'b1;
                info_ok = 1'b1;
                r.status = take_byte(b);
            end
            ACT_NEXT: begin
                if (parse_pos != 0) r.status = take_byte(b);
            end
            ACT_SEEK: begin
                if (hdr_ok && flags[FLG_TOC] && bytes_cnt != 0) begin
                    r.status = ST_SEEK_OK;
                    r.seek_point = seek_target(pct);
                end else begin
                    r.status = ST_SEEK_REF;
                end
            end
            default: ;
        endcase
        r.frames = frames_cnt;
        r.bytes = bytes_cnt;
        r.quality = quality_cnt;
        r.table_present = (parse_pos == 0) && flags[FLG_TOC];
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_parser();
            for (int i = 0; i < TOC_LEN; i++) toc[i] = '0;
            expected_beats.delete();
            o_fail_count = 0;
        end else begin
            // result side first: a beat never answers the item taken at the same edge
            if (i_out_valid && !i_out_stall) begin
                got_beat.status = i_status;
                got_beat.seek_point = i_seek_point;
                got_beat.frames = i_frame_total;
                got_beat.bytes = i_byte_total;
                got_beat.quality = i_quality_word;
                got_beat.table_present = i_table_present;
                if (expected_beats.size() == 0) begin
                    report_mismatch("beat with nothing expected", 32'(got_beat.status), '0);
                end else begin
                    want_beat = expected_beats.pop_front();
                    if (got_beat.status !== want_beat.status)
                        report_mismatch("status", 32'(got_beat.status), 32'(want_beat.status));
                    if (got_beat.seek_point !== want_beat.seek_point)
                        report_mismatch("seek_point", got_beat.seek_point, want_beat.seek_point);
                    if (got_beat.frames !== want_beat.frames)
                        report_mismatch("frame_total", got_beat.frames, want_beat.frames);
                    if (got_beat.bytes !== want_beat.bytes)
                        report_mismatch("byte_total", got_beat.bytes, want_beat.bytes);
                    if (got_beat.quality !== want_beat.quality)
                        report_mismatch("quality_word", got_beat.quality, want_beat.quality);
                    if (got_beat.table_present !== want_beat.table_present)
                        report_mismatch("table_present", 32'(got_beat.table_present),
                                        32'(want_beat.table_present));
                end
            end
            if (i_in_valid && !i_in_stall)
                expected_beats.push_back(predict_beat(i_action, i_header_byte, i_seek_percent));
        end
        o_pending = expected_beats.size();
    end

endmodule

// ----- tb/xing_vbr_header_toc_seek_core_tb.sv -----
// testbench top for xing_vbr_header_toc_seek_core: clock, reset, stimulus and verdict
// depends on xvts_pkg, the block and xvts_result_checker

module xing_vbr_header_toc_seek_core_tb;
    import xvts_pkg::*;

    localparam logic [1:0] ACT_UNUSED   = 2'd3;
    localparam int         ITEM_TARGET  = 2000;
    localparam int         IDLE_LIMIT   = 2000;
    localparam int         SETTLE_TICKS = 16;

    typedef enum {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_PERIODIC} t_rx_mode;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [1:0]  i_action;
    logic [7:0]  i_header_byte;
    logic [15:0] i_seek_percent;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [2:0]  o_status;
    logic [31:0] o_seek_point;
    logic [31:0] o_frame_total;
    logic [31:0] o_byte_total;
    logic [31:0] o_quality_word;
    logic        o_table_present;

    int          n_pending;
    int          n_fail;
    int          items_sent;
    int          burst_left;
    int          idle_cycles = 0;
    int          stall_left = 0;
    int          rx_phase = 0;
    t_rx_mode    stall_mode = RX_OPEN;
    logic [7:0]  hdr_bytes [$];

    xing_vbr_header_toc_seek_core i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_action        (i_action),
        .i_header_byte   (i_header_byte),
        .i_seek_percent  (i_seek_percent),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_status        (o_status),
        .o_seek_point    (o_seek_point),
        .o_frame_total   (o_frame_total),
        .o_byte_total    (o_byte_total),
        .o_quality_word  (o_quality_word),
        .o_table_present (o_table_present)
    );

    xvts_result_checker i_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_valid),
        .i_in_stall      (o_stall),
        .i_action        (i_action),
        .i_header_byte   (i_header_byte),
        .i_seek_percent  (i_seek_percent),
        .i_out_valid     (o_valid),
        .i_out_stall     (i_stall),
        .i_status        (o_status),
        .i_seek_point    (o_seek_point),
        .i_frame_total   (o_frame_total),
        .i_byte_total    (o_byte_total),
        .i_quality_word  (o_quality_word),
        .i_table_present (o_table_present),
        .o_pending       (n_pending),
        .o_fail_count    (n_fail)
    );

    always #1 i_clk = ~i_clk;

    // receiver stall pattern, mode redrawn at random whenever stall_left runs out
    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = t_rx_mode'($urandom_range(0, 3));
            stall_left = $urandom_range(20, 300);
        end else begin
            stall_left--;
        end
        rx_phase++;
        case (stall_mode)
            RX_OPEN:  i_stall <= 1'b0;
            RX_LIGHT: i_stall <= ($urandom_range(0, 3) == 0);
            RX_HEAVY: i_stall <= ($urandom_range(0, 3) != 0);
            default:  i_stall <= ((rx_phase % 7) < 3);
        endcase
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic send_item(input logic [1:0] act, input logic [7:0] hb,
                             input logic [15:0] pct);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 9);
            repeat (gap) begin
                @(negedge i_clk);
                i_valid <= 1'b0;
            end
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 12);
        end
        @(negedge i_clk);
        i_valid        <= 1'b1;
        i_action       <= act;
        i_header_byte  <= hb;
        i_seek_percent <= pct;
        do @(posedge i_clk); while (o_stall);
        burst_left--;
        items_sent++;
    endtask

    task automatic wait_all_results();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (n_pending != 0) @(negedge i_clk);
    endtask

    function automatic void push_word(input logic [31:0] w);
        hdr_bytes.push_back(w[31:24]);
        hdr_bytes.push_back(w[23:16]);
        hdr_bytes.push_back(w[15:8]);
        hdr_bytes.push_back(w[7:0]);
    endfunction

    function automatic logic [31:0] pick_count();
        case ($urandom_range(0, 9))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return 32'd1;
            3: return $urandom_range(1, 5000);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_flag_word();
        logic [31:0] w;
        w = ($urandom_range(0, 1) == 0) ? 32'd0 : ($urandom & 32'hFFFF_FFF0);
        case ($urandom_range(0, 4))
            0, 1: w[3:0] = 4'b1111;
            2:    w[3:0] = 4'b0111;
            default: w[3:0] = 4'($urandom_range(0, 15));
        endcase
        return w;
    endfunction

    function automatic logic [15:0] pick_percent();
        case ($urandom_range(0, 7))
            0: return 16'd0;
            1: return PCT_MAX;
            2: return PCT_MAX - 16'd1;
            3: return 16'hFFFF;
            4: return 16'($urandom_range(25601, 65535));
            5: return {8'($urandom_range(0, 99)), 8'h00};
            default: return 16'($urandom_range(0, 25600));
        endcase
    endfunction

    // header from its id; optionally cut short at a random byte
    task automatic send_header(input bit use_xing, input logic [31:0] flag_word,
                               input logic [31:0] frames, input logic [31:0] bytes,
                               input logic [31:0] qual, input bit truncate);
        int lvl;
        int n;
        bit sorted;
        hdr_bytes.delete();
        for (int i = 0; i < 4; i++)
            hdr_bytes.push_back(use_xing ? ID_XING[i] : ID_INFO[i]);
        push_word(flag_word);
        if (flag_word[FLG_FRAMES]) push_word(frames);
        if (flag_word[FLG_BYTES]) push_word(bytes);
        if (flag_word[FLG_TOC]) begin
            lvl = $urandom_range(0, 16);
            sorted = ($urandom_range(0, 3) != 0);
            for (int i = 0; i < TOC_LEN; i++) begin
                if (sorted) begin
                    lvl = lvl + $urandom_range(0, 5);
                    if (lvl > 255) lvl = 255;
                    hdr_bytes.push_back(8'(lvl));
                end else begin
                    hdr_bytes.push_back(8'($urandom));
                end
            end
        end
        if (flag_word[FLG_QUAL]) push_word(qual);
        n = truncate ? $urandom_range(1, hdr_bytes.size() - 1) : hdr_bytes.size();
        for (int i = 0; i < n; i++)
            send_item((i == 0) ? ACT_START : ACT_NEXT, hdr_bytes[i], 16'($urandom));
    endtask

    task automatic send_bad_id();
        logic [7:0] id [4];
        int k;
        bit use_xing;
        use_xing = $urandom_range(0, 1);
        k = $urandom_range(0, 3);
        for (int i = 0; i < 4; i++) begin
            id[i] = use_xing ? ID_XING[i] : ID_INFO[i];
            if ($urandom_range(0, 4) == 0) id[i] = 8'($urandom);
        end
        id[k] = id[k] ^ 8'($urandom_range(1, 255));
        for (int i = 0; i < 4; i++)
            send_item((i == 0) ? ACT_START : ACT_NEXT, id[i], 16'($urandom));
    endtask

    initial begin
        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_action       = ACT_START;
        i_header_byte  = '0;
        i_seek_percent = '0;
        items_sent     = 0;
        burst_left     = 0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed corner cases
        send_item(ACT_SEEK, 8'h00, 16'h0000);
        send_item(ACT_NEXT, 8'hFF, 16'hFFFF);
        send_item(ACT_UNUSED, 8'hA5, 16'h5A5A);
        send_item(ACT_START, ID_XING[0], 16'h0000);
        send_item(ACT_NEXT, ID_XING[1], 16'h0000);
        send_item(ACT_NEXT, ID_XING[2], 16'h0000);
        send_item(ACT_NEXT, 8'h78, 16'h0000);
        send_item(ACT_START, ID_INFO[0], 16'h0000);
        send_item(ACT_NEXT, ID_INFO[1], 16'h0000);
        send_item(ACT_SEEK, 8'h00, PCT_MAX);
        send_header(1'b0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0);
        send_item(ACT_SEEK, 8'h00, 16'hFFFF);
        wait_all_results();

        while (items_sent < ITEM_TARGET) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5, 6: begin
                    send_header($urandom_range(0, 1), pick_flag_word(), pick_count(),
                                pick_count(), $urandom, 1'b0);
                    repeat ($urandom_range(1, 8))
                        send_item(ACT_SEEK, 8'($urandom), pick_percent());
                end
                7: begin
                    send_header($urandom_range(0, 1), pick_flag_word(), pick_count(),
                                pick_count(), $urandom, 1'b1);
                    repeat ($urandom_range(0, 2))
                        send_item(2'($urandom_range(1, 2)), 8'($urandom), pick_percent());
                end
                8: begin
                    send_bad_id();
                    repeat ($urandom_range(0, 2))
                        send_item(ACT_NEXT, 8'($urandom), 16'($urandom));
                end
                default: begin
                    repeat ($urandom_range(1, 6))
                        send_item(2'($urandom_range(0, 3)), 8'($urandom), 16'($urandom));
                end
            endcase
            if ($urandom_range(0, 19) == 0) wait_all_results();
        end

        wait_all_results();
        repeat (SETTLE_TICKS) @(negedge i_clk);
        if (n_fail == 0 && n_pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
